### rtl/avre_pkg.sv
// Shared types and constants of the acknowledgement vector run-length encoder.
package avre_pkg;

  // Operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ADD   = 2'd1,
    OP_FINAL = 2'd2
  } op_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_MAX_BYTES = 1'b0,
    CFG_NR_CODE   = 1'b1
  } cfg_idx_e;

  localparam int unsigned SeqW     = 64;
  localparam int unsigned LenW     = 7;
  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 24;

  localparam logic [LenW-1:0] VectorLimit   = 7'd127;
  localparam logic [LenW-1:0] MaxBytesReset = 7'd127;
  localparam logic [1:0]      NrCodeReset   = 2'd3;
  localparam logic [5:0]      RunFull       = 6'h3F;

  // One input item as unpacked from the stream
  typedef struct packed {
    logic [1:0]      operation;
    logic [SeqW-1:0] received_mark;
    logic [SeqW-1:0] first_received_mark;
    logic            start_parity;
    logic [1:0]      packet_state;
    logic            packet_parity;
  } in_t;

  // One result item
  typedef struct packed {
    logic            finished;
    logic            byte_write;
    logic            accepted;
    logic [LenW-1:0] vector_length;
    logic            final_parity;
    logic [7:0]      byte_value;
    logic [LenW-1:0] byte_index;
  } res_t;

endpackage

### rtl/ack_vector_rle_encoder.sv
// Top level of the acknowledgement vector run-length encoder.
//
//  channel  | direction | tdata (low bit first)                        | tuser
//  ---------+-----------+----------------------------------------------+---------------------
//  s_axis   | in        | received_mark, first_received_mark,          | operation
//           |           | start_parity, packet_state, packet_parity    |
//  m_axis   | out       | byte_index, byte_value, final_parity,        | accepted, byte_write,
//           |           | vector_length                                | finished
//  cfg      | in        | cfg_addr_i selects register, cfg_wdata_i     | -
//
// One item per clock while m_axis takes the results; an item is registered in
// the input register and then in the result register that drives m_axis.
// The encoder state updates in the same cycle the item moves into the
// result register, so consecutive items see each other's effects at once.
// The 64-bit sequence increment and compare set the critical path.
// Reset clears the encoder state and valid flags and sets the configuration to 127 bytes and code 3.
// A stall on m_axis holds the result; the input register still fills,
// then s_axis_tready drops until the result is taken.
module ack_vector_rle_encoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: received_mark[63:0], first_received_mark[127:64], start_parity[128],
  //        packet_state[130:129], packet_parity[131], zero pad[135:132]
  input  logic [avre_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [1:0]   s_axis_tuser,
  // master stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: byte_index[6:0], byte_value[14:7], final_parity[15],
  //        vector_length[22:16], zero pad[23]
  output logic [avre_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: accepted[0], byte_write[1], finished[2]
  output logic [2:0]   m_axis_tuser,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic         cfg_addr_i,
  input  logic [6:0]   cfg_wdata_i
);
  import avre_pkg::*;

  // configuration
  logic [LenW-1:0] max_bytes_q;
  logic [1:0]      nr_code_q;

  // input register
  logic in_valid_q;
  in_t  in_q;

  // result register
  logic out_valid_q;
  res_t res_q, res_d;

  // encoder state
  logic [SeqW-1:0] cur_seq_q, cur_seq_d;
  logic [SeqW-1:0] rx_limit_q, rx_limit_d;
  logic [SeqW-1:0] first_rx_q, first_rx_d;
  logic [7:0]      run_byte_q, run_byte_d;
  logic [LenW-1:0] filled_q, filled_d;
  logic [1:0]      last_state_q, last_state_d;
  logic            parity_q, parity_d;

  logic            advance;
  logic [SeqW-1:0] seq_inc;
  logic [LenW-1:0] byte_lim;
  logic            need_new;

  // Move the held item into the result register whenever that slot frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MaxBytesReset;
      nr_code_q   <= NrCodeReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_MAX_BYTES: max_bytes_q <= cfg_wdata_i;
        CFG_NR_CODE:   nr_code_q   <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Payload capture: unpack tdata into the item fields
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.operation           <= s_axis_tuser;
      in_q.received_mark       <= s_axis_tdata[63:0];
      in_q.first_received_mark <= s_axis_tdata[127:64];
      in_q.start_parity        <= s_axis_tdata[128];
      in_q.packet_state        <= s_axis_tdata[130:129];
      in_q.packet_parity       <= s_axis_tdata[131];
    end
  end

  // Effective byte limit is the register clamped to the vector size
  assign byte_lim = (max_bytes_q > VectorLimit) ? VectorLimit : max_bytes_q;
  assign seq_inc  = cur_seq_q + 64'd1;
  // A fresh byte is needed when the state changes or the run is saturated
  assign need_new = (last_state_q != in_q.packet_state) || (run_byte_q[5:0] == RunFull);

  always_comb begin
    cur_seq_d    = cur_seq_q;
    rx_limit_d   = rx_limit_q;
    first_rx_d   = first_rx_q;
    run_byte_d   = run_byte_q;
    filled_d     = filled_q;
    last_state_d = last_state_q;
    parity_d     = parity_q;
    res_d        = '0;

    case (in_q.operation)
      OP_START: begin
        rx_limit_d     = in_q.received_mark;
        first_rx_d     = in_q.first_received_mark;
        cur_seq_d      = in_q.first_received_mark;
        parity_d       = in_q.start_parity;
        filled_d       = '0;
        run_byte_d     = '0;
        last_state_d   = '0;
        res_d.accepted = 1'b1;
      end
      OP_ADD: begin
        // The sequence number advances even when the add is refused
        cur_seq_d = seq_inc;
        if (seq_inc < rx_limit_q) begin
          if (filled_q == '0) begin
            if (byte_lim != '0) begin
              run_byte_d       = {in_q.packet_state, 6'd1};
              filled_d         = 7'd1;
              res_d.accepted   = 1'b1;
              res_d.byte_index = '0;
            end
          end else if (need_new) begin
            if (filled_q < byte_lim) begin
              run_byte_d       = {in_q.packet_state, 6'd1};
              filled_d         = filled_q + 7'd1;
              res_d.accepted   = 1'b1;
              res_d.byte_index = filled_q;
            end
          end else begin
            run_byte_d       = {run_byte_q[7:6], run_byte_q[5:0] + 6'd1};
            res_d.accepted   = 1'b1;
            res_d.byte_index = filled_q - 7'd1;
          end
          if (res_d.accepted) begin
            last_state_d     = in_q.packet_state;
            if (in_q.packet_state != nr_code_q) begin
              parity_d = parity_q ^ in_q.packet_parity;
            end
            res_d.byte_write = 1'b1;
            res_d.byte_value = run_byte_d;
          end
        end
      end
      OP_FINAL: begin
        res_d.accepted     = 1'b1;
        res_d.finished     = 1'b1;
        res_d.final_parity = parity_q;
        // Nothing worth sending: empty, equal marks, or a lone not-received run
        if ((filled_q == '0) || (first_rx_q == rx_limit_q) ||
            ((filled_q == 7'd1) && (last_state_q == nr_code_q))) begin
          res_d.vector_length = '0;
        end else begin
          res_d.vector_length = filled_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_seq_q    <= '0;
      rx_limit_q   <= '0;
      first_rx_q   <= '0;
      run_byte_q   <= '0;
      filled_q     <= '0;
      last_state_q <= '0;
      parity_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        cur_seq_q    <= cur_seq_d;
        rx_limit_q   <= rx_limit_d;
        first_rx_q   <= first_rx_d;
        run_byte_q   <= run_byte_d;
        filled_q     <= filled_d;
        last_state_q <= last_state_d;
        parity_q     <= parity_d;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.vector_length, res_q.final_parity,
                          res_q.byte_value, res_q.byte_index};
  assign m_axis_tuser  = {res_q.finished, res_q.byte_write, res_q.accepted};

endmodule

### rtl/avre_checker.sv
// Port-level checks for the run-length encoder, bound to its top level.
module avre_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [avre_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);
  import avre_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A finalize result never carries a byte write
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[2] && m_axis_tuser[1]))
    else $error("finish and byte write together");

  // Only accepted items write a byte or finish
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1] || m_axis_tuser[2]) |-> m_axis_tuser[0])
    else $error("write or finish without accept");

  // A refused item carries an all-zero payload
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0))
    else $error("refused item with data");

  // A written byte always holds a run of at least one
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata[12:7] != 6'd0))
    else $error("empty run written");

endmodule

bind ack_vector_rle_encoder avre_checker u_avre_checker (.*);
